// ===== sv/sdhd_pkg.sv =====
// ----------------------------------------------------------------------------
// sdhd_pkg
// Shared types and constants for the switch debounce and hold detector.
// ----------------------------------------------------------------------------
`default_nettype none

package sdhd_pkg;

  // Input operation codes.
  localparam logic OP_POLL = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  // Configuration register indexes (address bit 2).
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_HOLD     = 1'b1;

  localparam int DEBOUNCE_W = 8;
  localparam int HOLD_W     = 16;
  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 3;
  localparam int CACHE_W    = 4;
  localparam int CODE_W     = 5;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd50;
  localparam logic [HOLD_W-1:0]     HOLD_RESET     = 16'd1000;

  localparam logic [LEVEL_W-1:0] LEVEL_ALL_RELEASED = 3'b111;
  localparam logic [LEVEL_W-1:0] LEVEL_ALL_LOW      = 3'b000;
  localparam logic [CACHE_W-1:0] CODE_ALL_LOW_MARK  = 4'b1000;

  typedef struct packed {
    logic                  pending;
    logic [TIME_W-1:0]     edge_time;
    logic [TIME_W-1:0]     last_report_time;
    logic                  hold_active;
    logic [CACHE_W-1:0]    cached_code;
  } sdhd_state_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic [HOLD_W-1:0]     hold_ms;
  } sdhd_cfg_t;

endpackage

`default_nettype wire

// ===== sv/sdhd_if.sv =====
// ----------------------------------------------------------------------------
// sdhd_sw_if / sdhd_key_if
// Valid/ready channels for switch events and reported key codes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdhd_sw_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [sdhd_pkg::TIME_W-1:0]    now_ms;
  logic [sdhd_pkg::LEVEL_W-1:0]   line_levels;

  modport source (output valid, output op, output now_ms, output line_levels, input ready);
  modport sink   (input valid, input op, input now_ms, input line_levels, output ready);
endinterface

interface sdhd_key_if;
  logic                           valid;
  logic                           ready;
  logic [sdhd_pkg::CODE_W-1:0]    key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

`default_nettype wire

// ===== sv/switch_debounce_hold_detector_unit.sv =====
// A key code appears on the output register in the cycle after its item is accepted.
// Throughput: one item per cycle when key.ready is high; the register frees as it is taken.
// The rate is set by the single pass from the press state registers to the output register.
// Reset (synchronous, rst high) clears the press state and the output valid, and loads
// debounce_ms with 50 and hold_ms with 1000.
// ----------------------------------------------------------------------------
// switch_debounce_hold_detector_unit
// Debounces a three-line active-low switch group and reports presses and holds.
// ----------------------------------------------------------------------------
`default_nettype none

module switch_debounce_hold_detector_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sdhd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [sdhd_pkg::DATA_W-1:0]   pwdata,
  output logic      [sdhd_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  sdhd_sw_if.sink                            sw,
  sdhd_key_if.source                         key
);

  sdhd_pkg::sdhd_cfg_t             cfg;
  sdhd_pkg::sdhd_state_t           state;
  sdhd_pkg::sdhd_state_t           state_next;
  logic [sdhd_pkg::CODE_W-1:0]     code_next;
  logic                            accept;
  logic                            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms <= sdhd_pkg::DEBOUNCE_RESET;
      cfg.hold_ms     <= sdhd_pkg::HOLD_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        sdhd_pkg::REG_DEBOUNCE: cfg.debounce_ms <= pwdata[sdhd_pkg::DEBOUNCE_W-1:0];
        sdhd_pkg::REG_HOLD:     cfg.hold_ms     <= pwdata[sdhd_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sdhd_pkg::REG_DEBOUNCE:
        prdata = {{(sdhd_pkg::DATA_W-sdhd_pkg::DEBOUNCE_W){1'b0}}, cfg.debounce_ms};
      sdhd_pkg::REG_HOLD:
        prdata = {{(sdhd_pkg::DATA_W-sdhd_pkg::HOLD_W){1'b0}}, cfg.hold_ms};
      default:
        prdata = '0;
    endcase
  end

  sdhd_core u_core (
    .state       (state),
    .cfg         (cfg),
    .op          (sw.op),
    .now_ms      (sw.now_ms),
    .line_levels (sw.line_levels),
    .state_next  (state_next),
    .key_code    (code_next)
  );

  // A new item enters whenever the output register is empty or being drained.
  assign sw.ready = !key.valid || key.ready;
  assign accept   = sw.valid && sw.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      key.valid <= 1'b0;
    end else if (accept) begin
      state     <= state_next;
      key.valid <= 1'b1;
    end else if (key.ready) begin
      key.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key.key_code <= code_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sdhd_core.sv =====
// ----------------------------------------------------------------------------
// sdhd_core
// Next-state and key code logic for one switch event or poll.
// ----------------------------------------------------------------------------
`default_nettype none

module sdhd_core (
  input  var sdhd_pkg::sdhd_state_t          state,
  input  var sdhd_pkg::sdhd_cfg_t            cfg,
  input  wire logic                          op,
  input  wire logic [sdhd_pkg::TIME_W-1:0]   now_ms,
  input  wire logic [sdhd_pkg::LEVEL_W-1:0]  line_levels,
  output sdhd_pkg::sdhd_state_t              state_next,
  output logic [sdhd_pkg::CODE_W-1:0]        key_code
);

  logic [sdhd_pkg::TIME_W-1:0] since_report;
  logic [sdhd_pkg::TIME_W-1:0] since_edge;
  logic                        in_window;
  logic                        held_long;

  // Elapsed times wrap modulo 2^32, which plain unsigned subtraction gives.
  assign since_report = now_ms - state.last_report_time;
  assign since_edge   = now_ms - state.edge_time;
  assign in_window    = since_report <
                        {{(sdhd_pkg::TIME_W-sdhd_pkg::DEBOUNCE_W){1'b0}}, cfg.debounce_ms};
  assign held_long    = since_edge >
                        {{(sdhd_pkg::TIME_W-sdhd_pkg::HOLD_W){1'b0}}, cfg.hold_ms};

  always_comb begin
    state_next = state;
    key_code   = '0;
    if (op == sdhd_pkg::OP_EDGE) begin
      state_next.pending   = 1'b1;
      state_next.edge_time = now_ms;
    end else if (state.pending) begin
      if (in_window) begin
        // A bounce inside the window drops the cached level unless a hold runs.
        if (!state.hold_active) begin
          state_next.cached_code = '0;
        end
      end else if (line_levels == sdhd_pkg::LEVEL_ALL_RELEASED) begin
        state_next.pending = 1'b0;
        if (state.hold_active) begin
          state_next.hold_active = 1'b0;
        end else begin
          state_next.last_report_time = now_ms;
          key_code                    = {1'b0, state.cached_code};
        end
      end else if (held_long) begin
        state_next.hold_active      = 1'b1;
        state_next.last_report_time = now_ms;
        key_code                    = {1'b1, state.cached_code};
      end else if (line_levels == sdhd_pkg::LEVEL_ALL_LOW) begin
        state_next.cached_code = sdhd_pkg::CODE_ALL_LOW_MARK;
      end else begin
        state_next.cached_code = {1'b0, line_levels};
      end
    end
  end

endmodule

`default_nettype wire
